>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the decoder RTL.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define MBD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition must never hold at a clock edge outside reset.
`define MBD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// If the trigger holds, the consequence holds in the following cycle.
`define MBD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

>>> rtl/mbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg
// Types, opcode pattern constants and length helpers for the 8086 subset
// decoder (mov/add rm-reg, mov imm-reg, immediate group).
// ----------------------------------------------------------------------------
package mbd_pkg;

  // Instruction form codes as they appear on the result channel
  typedef enum logic [2:0] {
    FORM_MOV_RM  = 3'd0,
    FORM_MOV_IMM = 3'd1,
    FORM_ADD_RM  = 3'd2,
    FORM_IMM_GRP = 3'd3,
    FORM_INVALID = 3'd4
  } form_t;

  // Opcode bit patterns
  localparam logic [2:0] OP_TOP_MOV_IMM = 3'b101;
  localparam logic [2:0] OP_TOP_GRP     = 3'b100;
  localparam logic [2:0] OP_MID_MOV_RM  = 3'b010;
  localparam logic [2:0] OP_MID_ZERO    = 3'b000;
  localparam logic [2:0] OP_TOP_ADD     = 3'b000;
  localparam logic [1:0] MOD_REG        = 2'b11;
  localparam logic [1:0] MOD_DISP8      = 2'b01;
  localparam logic [1:0] MOD_DISP16     = 2'b10;
  localparam logic [1:0] MOD_MEM        = 2'b00;
  localparam logic [2:0] RM_DIRECT      = 3'b110;
  localparam logic [1:0] SW_WORD_IMM    = 2'b01;

  // Default depth of the queue between collector and formatter
  localparam int unsigned QUEUE_DEPTH = 2;

  // Raw collected instruction bytes
  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] imm;
  } mbd_rec_t;

  // Decoded result record
  typedef struct packed {
    form_t              form;
    logic               wide;
    logic               reg_is_dest;
    logic               sign_extend;
    logic [1:0]         mode;
    logic [2:0]         reg_field;
    logic [2:0]         rm_field;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
    logic [2:0]         length;
  } mbd_res_t;

  function automatic form_t classify(input logic [7:0] op);
    logic [2:0] top;
    logic [2:0] mid;
    top = op[7:5];
    mid = op[4:2];
    if (top == OP_TOP_MOV_IMM && op[4])                 return FORM_MOV_IMM;
    else if (top == OP_TOP_GRP && mid == OP_MID_MOV_RM) return FORM_MOV_RM;
    else if (top == OP_TOP_GRP && mid == OP_MID_ZERO)   return FORM_IMM_GRP;
    else if (top == OP_TOP_ADD && mid == OP_MID_ZERO)   return FORM_ADD_RM;
    else                                                return FORM_INVALID;
  endfunction

  // Displacement bytes following the mod-reg-rm byte
  function automatic logic [1:0] disp_len(input form_t form, input logic [7:0] m);
    if (form == FORM_MOV_IMM || form == FORM_INVALID) return 2'd0;
    else if (m[7:6] == MOD_DISP8)                     return 2'd1;
    else if (m[7:6] == MOD_DISP16)                    return 2'd2;
    else if (m[7:6] == MOD_MEM && m[2:0] == RM_DIRECT) return 2'd2;
    else                                              return 2'd0;
  endfunction

  // Immediate bytes
  function automatic logic [1:0] imm_len(input form_t form, input logic [7:0] op);
    if (form == FORM_MOV_IMM)      return op[3] ? 2'd2 : 2'd1;
    else if (form == FORM_IMM_GRP) return (op[1:0] == SW_WORD_IMM) ? 2'd2 : 2'd1;
    else                           return 2'd0;
  endfunction

  // Total instruction length in bytes
  function automatic logic [2:0] total_len(input form_t form, input logic [7:0] op,
                                           input logic [7:0] m);
    if (form == FORM_INVALID)      return 3'd1;
    else if (form == FORM_MOV_IMM) return 3'd1 + {1'b0, imm_len(form, op)};
    else return 3'd2 + {1'b0, disp_len(form, m)} + {1'b0, imm_len(form, op)};
  endfunction

endpackage

>>> rtl/mbd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_in_if
// Code byte channel: one instruction stream byte per request.
// ----------------------------------------------------------------------------
interface mbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

>>> rtl/mbd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_out_if
// Decoded instruction channel: one record per request.
// ----------------------------------------------------------------------------
interface mbd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         form;
  logic               wide;
  logic               reg_is_dest;
  logic               sign_extend;
  logic [1:0]         mode;
  logic [2:0]         reg_field;
  logic [2:0]         rm_field;
  logic signed [15:0] displacement;
  logic signed [15:0] immediate;
  logic [2:0]         length;

  modport source (output valid, output form, output wide, output reg_is_dest,
                  output sign_extend, output mode, output reg_field, output rm_field,
                  output displacement, output immediate, output length, input ready);
  modport sink   (input valid, input form, input wide, input reg_is_dest,
                  input sign_extend, input mode, input reg_field, input rm_field,
                  input displacement, input immediate, input length, output ready);
endinterface

>>> rtl/mbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_front
// Byte collector: classifies the opcode, gathers mod-reg-rm, displacement and
// immediate bytes, and pushes a raw record once an instruction is complete.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbd_front (
  input  logic              clk,
  input  logic              rst_n,
  mbd_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              q_push,
  output mbd_pkg::mbd_rec_t q_rec
);

  logic [2:0]  cnt_r,   cnt_nxt;
  logic [7:0]  op_r,    op_nxt;
  logic [7:0]  modrm_r, modrm_nxt;
  logic [15:0] disp_r,  disp_nxt;
  logic [15:0] imm_r,   imm_nxt;

  logic            fire;
  logic [7:0]      b;
  mbd_pkg::form_t  form;
  logic            has_modrm;
  logic [2:0]      pos;
  logic [1:0]      dl;
  logic [2:0]      total;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && !q_full;
  assign b           = in_ch.code_byte;

  // Per-byte collection
  always_comb begin
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    modrm_nxt = modrm_r;
    disp_nxt  = disp_r;
    imm_nxt   = imm_r;
    q_push    = 1'b0;
    form      = mbd_pkg::classify(op_r);
    has_modrm = (form != mbd_pkg::FORM_MOV_IMM) && (form != mbd_pkg::FORM_INVALID);
    pos       = cnt_r - (has_modrm ? 3'd2 : 3'd1);
    dl        = mbd_pkg::disp_len(form, modrm_r);
    total     = 3'd1;
    if (fire) begin
      if (cnt_r == 3'd0) begin
        // opcode byte
        op_nxt    = b;
        modrm_nxt = 8'h00;
        disp_nxt  = 16'h0000;
        imm_nxt   = 16'h0000;
        if (mbd_pkg::classify(b) == mbd_pkg::FORM_INVALID) begin
          q_push = 1'b1;
        end else begin
          cnt_nxt = 3'd1;
        end
      end else begin
        if (has_modrm && cnt_r == 3'd1) begin
          modrm_nxt = b;
        end else if (pos < {1'b0, dl}) begin
          disp_nxt = (pos == 3'd0) ? {8'h00, b} : {b, disp_r[7:0]};
        end else if (pos == {1'b0, dl}) begin
          imm_nxt = {8'h00, b};
        end else begin
          imm_nxt = {b, imm_r[7:0]};
        end
        total = mbd_pkg::total_len(form, op_r, modrm_nxt);
        if (cnt_r + 3'd1 >= total) begin
          q_push  = 1'b1;
          cnt_nxt = 3'd0;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
    end
  end

  assign q_rec = '{opcode: op_nxt, modrm: modrm_nxt, disp: disp_nxt, imm: imm_nxt};

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 3'd0;
      op_r    <= 8'h00;
      modrm_r <= 8'h00;
      disp_r  <= 16'h0000;
      imm_r   <= 16'h0000;
    end else begin
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
      modrm_r <= modrm_nxt;
      disp_r  <= disp_nxt;
      imm_r   <= imm_nxt;
    end
  end

  // Checks
  `MBD_ASSERT_NEVER(a_cnt_range, cnt_r > 3'd5, "byte count beyond longest instruction")
  `MBD_ASSERT_NEVER(a_push_when_full, q_push && q_full, "push into full queue")
  `MBD_ASSERT_NEXT(a_push_restarts, q_push, cnt_r == 3'd0, "count not cleared after push")

endmodule

>>> rtl/mbd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_queue
// Small FIFO of raw instruction records between collector and formatter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbd_queue #(
  parameter int unsigned DEPTH = mbd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mbd_pkg::mbd_rec_t push_rec,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output mbd_pkg::mbd_rec_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mbd_pkg::mbd_rec_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  // Checks
  `MBD_ASSERT_ALWAYS(a_count_range, count_r <= CW'(DEPTH), "queue count overflow")
  `MBD_ASSERT_NEVER(a_pop_empty, pop && empty, "pop from empty queue")
  `MBD_ASSERT_NEXT(a_push_fills, push && !pop && !full, !empty, "queue empty after push")

endmodule

>>> rtl/mbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_back
// Formatter: takes raw records from the queue, extracts the decoded fields and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module mbd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  mbd_pkg::mbd_rec_t q_head,
  output logic              q_pop,
  mbd_out_if.source         out_ch
);

  logic              out_valid_r, out_valid_nxt;
  mbd_pkg::mbd_res_t res_r;
  mbd_pkg::mbd_res_t res;

  mbd_pkg::form_t form;
  logic [7:0]     op;
  logic [7:0]     m;
  logic [1:0]     dl;
  logic [1:0]     il;

  // Pop when the output register is free or being drained
  assign q_pop         = !q_empty && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = q_pop || (out_valid_r && !out_ch.ready);

  // Field extraction
  always_comb begin
    op   = q_head.opcode;
    m    = q_head.modrm;
    form = mbd_pkg::classify(op);
    dl   = mbd_pkg::disp_len(form, m);
    il   = mbd_pkg::imm_len(form, op);
    res  = '0;
    res.form   = form;
    res.length = mbd_pkg::total_len(form, op, m);
    unique case (form) inside
      mbd_pkg::FORM_MOV_RM, mbd_pkg::FORM_ADD_RM: begin
        res.wide        = op[0];
        res.reg_is_dest = op[1];
        res.mode        = m[7:6];
        res.reg_field   = m[5:3];
        res.rm_field    = m[2:0];
      end
      mbd_pkg::FORM_IMM_GRP: begin
        res.wide        = op[0];
        res.sign_extend = op[1];
        res.mode        = m[7:6];
        res.reg_field   = m[5:3];
        res.rm_field    = m[2:0];
      end
      mbd_pkg::FORM_MOV_IMM: begin
        res.wide        = op[3];
        res.reg_is_dest = 1'b1;
        res.mode        = mbd_pkg::MOD_REG;
        res.reg_field   = op[2:0];
      end
      default: begin
        res.wide = 1'b0;
      end
    endcase
    // byte-wide values are sign-extended
    case (dl)
      2'd1:    res.displacement = {{8{q_head.disp[7]}}, q_head.disp[7:0]};
      2'd2:    res.displacement = q_head.disp;
      default: res.displacement = 16'sd0;
    endcase
    case (il)
      2'd1:    res.immediate = {{8{q_head.imm[7]}}, q_head.imm[7:0]};
      2'd2:    res.immediate = q_head.imm;
      default: res.immediate = 16'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.form         = res_r.form;
  assign out_ch.wide         = res_r.wide;
  assign out_ch.reg_is_dest  = res_r.reg_is_dest;
  assign out_ch.sign_extend  = res_r.sign_extend;
  assign out_ch.mode         = res_r.mode;
  assign out_ch.reg_field    = res_r.reg_field;
  assign out_ch.rm_field     = res_r.rm_field;
  assign out_ch.displacement = res_r.displacement;
  assign out_ch.immediate    = res_r.immediate;
  assign out_ch.length       = res_r.length;

endmodule

>>> rtl/x86_16bit_mov_add_byte_decoder.sv
`timescale 1ns / 1ps
// After the last byte of its instruction, a record is written to the record queue and then to the output register.
// Throughput: one code byte per cycle, one record per cycle at most.
// Input stalls only when the record queue between collector and formatter is full.
// Reset: synchronous active-low; clears byte count, queue and output valid.
// ----------------------------------------------------------------------------
// x86_16bit_mov_add_byte_decoder
// Byte-serial decoder for mov/add rm-reg, mov imm-reg and the immediate group.
// ----------------------------------------------------------------------------
module x86_16bit_mov_add_byte_decoder #(
  parameter int unsigned QUEUE_DEPTH = mbd_pkg::QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  mbd_in_if.sink    in_ch,
  mbd_out_if.source out_ch
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  mbd_pkg::mbd_rec_t q_rec;
  mbd_pkg::mbd_rec_t q_head;

  // Collector
  mbd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (q_rec)
  );

  // Record queue
  mbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Formatter
  mbd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> sim/tb_x86_16bit_mov_add_byte_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x86_16bit_mov_add_byte_decoder
// Streams 8086 code bytes into the decoder and checks every decoded record
// against a byte-serial decode model kept in the bench. A short directed
// table covers each form, the displacement and immediate sizes and the
// unknown-opcode record. Random instructions with random operands and some
// stray bytes follow. Both channels idle at random in four phases.
// ----------------------------------------------------------------------------
module tb_x86_16bit_mov_add_byte_decoder;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_BYTES = 750;
  localparam int STALL_LIMIT  = 2000;  // cycles with no request on either side
  localparam int DRAIN_CYCLES = 10;    // extra wait once no record is pending

  // Directed stream: bit 8 marks an unknown opcode whose record is typed in
  localparam logic [8:0] DIRECTED [25] = '{
    {1'b1, 8'hFF},                                 // unknown opcode
    {1'b0, 8'h8B}, {1'b0, 8'hC1},                  // mov ax, cx
    {1'b0, 8'h01}, {1'b0, 8'h46}, {1'b0, 8'h80},   // add [bp-128], ax
    {1'b0, 8'hB8}, {1'b0, 8'hFF}, {1'b0, 8'h7F},   // mov ax, 7fffh
    {1'b0, 8'hB0}, {1'b0, 8'h80},                  // mov al, -128
    {1'b0, 8'h83}, {1'b0, 8'h06}, {1'b0, 8'h34},   // add word [1234h], -1
    {1'b0, 8'h12}, {1'b0, 8'hFF},                  //   direct address, s=1
    {1'b0, 8'h81}, {1'b0, 8'h80}, {1'b0, 8'h00},   // add word [bx+si-8000h],
    {1'b0, 8'h80}, {1'b0, 8'hFF}, {1'b0, 8'hFF},   //   0ffffh
    {1'b0, 8'h00}, {1'b0, 8'h00},                  // add [bx+si], al
    {1'b1, 8'h0F}                                  // unknown opcode
  };

  typedef struct packed {
    logic [7:0] code;
    logic       typed_bad;
  } code_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mbd_in_if  in_ch ();
  mbd_out_if out_ch ();

  x86_16bit_mov_add_byte_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  code_row_t          rows [$];
  mbd_pkg::mbd_res_t  pending_records [$];
  mbd_pkg::mbd_res_t  bad_rec;
  int                 mismatches     = 0;
  int                 send_gap_pct   = 0;
  int                 recv_stall_pct = 0;
  int                 stall_cycles   = 0;

  // Decode state: bytes seen of the current instruction and what they held
  logic [2:0]  dec_count = '0;
  logic [7:0]  dec_op    = '0;
  logic [7:0]  dec_modrm = '0;
  logic [15:0] dec_disp  = '0;
  logic [15:0] dec_imm   = '0;

  function automatic mbd_pkg::form_t form_of(input logic [7:0] op);
    if (op[7:5] == mbd_pkg::OP_TOP_MOV_IMM && op[4]) return mbd_pkg::FORM_MOV_IMM;
    if (op[7:5] == mbd_pkg::OP_TOP_GRP && op[4:2] == mbd_pkg::OP_MID_MOV_RM)
      return mbd_pkg::FORM_MOV_RM;
    if (op[7:5] == mbd_pkg::OP_TOP_GRP && op[4:2] == mbd_pkg::OP_MID_ZERO)
      return mbd_pkg::FORM_IMM_GRP;
    if (op[7:5] == mbd_pkg::OP_TOP_ADD && op[4:2] == mbd_pkg::OP_MID_ZERO)
      return mbd_pkg::FORM_ADD_RM;
    return mbd_pkg::FORM_INVALID;
  endfunction

  function automatic int disp_bytes(input mbd_pkg::form_t f, input logic [7:0] m);
    if (f == mbd_pkg::FORM_MOV_IMM || f == mbd_pkg::FORM_INVALID) return 0;
    case (m[7:6])
      mbd_pkg::MOD_DISP8:  return 1;
      mbd_pkg::MOD_DISP16: return 2;
      mbd_pkg::MOD_MEM:    return (m[2:0] == mbd_pkg::RM_DIRECT) ? 2 : 0;
      default:             return 0;
    endcase
  endfunction

  function automatic int imm_bytes(input mbd_pkg::form_t f, input logic [7:0] op);
    if (f == mbd_pkg::FORM_MOV_IMM) return op[3] ? 2 : 1;
    if (f == mbd_pkg::FORM_IMM_GRP) return (op[1:0] == mbd_pkg::SW_WORD_IMM) ? 2 : 1;
    return 0;
  endfunction

  function automatic int instr_length(input logic [7:0] op, input logic [7:0] m);
    mbd_pkg::form_t f;
    f = form_of(op);
    if (f == mbd_pkg::FORM_INVALID) return 1;
    if (f == mbd_pkg::FORM_MOV_IMM) return 1 + imm_bytes(f, op);
    return 2 + disp_bytes(f, m) + imm_bytes(f, op);
  endfunction

  // Operand byte, biased toward the sign boundaries
  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Advance the decode state by one code byte; done when a record is due
  task automatic decode_byte(input logic [7:0] b, output bit done,
                             output mbd_pkg::mbd_res_t rec);
    mbd_pkg::form_t f;
    int             nd;
    int             ni;
    int             pos;
    bit             has_modrm;
    done = 1'b0;
    rec  = '0;
    if (dec_count == 3'd0) begin
      dec_op    = b;
      dec_modrm = '0;
      dec_disp  = '0;
      dec_imm   = '0;
      if (form_of(b) == mbd_pkg::FORM_INVALID) done = 1'b1;
      else dec_count = 3'd1;
    end else begin
      f = form_of(dec_op);
      has_modrm = (f != mbd_pkg::FORM_MOV_IMM);
      if (has_modrm && dec_count == 3'd1) begin
        dec_modrm = b;
      end else begin
        // displacement bytes first, then immediate, low byte first
        pos = int'(dec_count) - (has_modrm ? 2 : 1);
        nd  = disp_bytes(f, dec_modrm);
        if (pos == 0 && nd > 0) dec_disp = {8'h00, b};
        else if (pos < nd) dec_disp[15:8] = b;
        else if (pos == nd) dec_imm = {8'h00, b};
        else dec_imm[15:8] = b;
      end
      if (int'(dec_count) + 1 >= instr_length(dec_op, dec_modrm)) begin
        done = 1'b1;
        dec_count = 3'd0;
      end else begin
        dec_count = dec_count + 3'd1;
      end
    end

    // Assemble the record from the stored bytes
    if (done) begin
      f  = form_of(dec_op);
      nd = disp_bytes(f, dec_modrm);
      ni = imm_bytes(f, dec_op);
      rec.form   = f;
      rec.length = 3'(instr_length(dec_op, dec_modrm));
      if (f == mbd_pkg::FORM_MOV_IMM) begin
        rec.wide        = dec_op[3];
        rec.reg_is_dest = 1'b1;
        rec.mode        = mbd_pkg::MOD_REG;
        rec.reg_field   = dec_op[2:0];
      end else if (f != mbd_pkg::FORM_INVALID) begin
        rec.wide        = dec_op[0];
        rec.reg_is_dest = (f == mbd_pkg::FORM_IMM_GRP) ? 1'b0 : dec_op[1];
        rec.sign_extend = (f == mbd_pkg::FORM_IMM_GRP) ? dec_op[1] : 1'b0;
        rec.mode        = dec_modrm[7:6];
        rec.reg_field   = dec_modrm[5:3];
        rec.rm_field    = dec_modrm[2:0];
      end
      if (nd == 1) rec.displacement = {{8{dec_disp[7]}}, dec_disp[7:0]};
      else if (nd == 2) rec.displacement = dec_disp;
      if (ni == 1) rec.immediate = {{8{dec_imm[7]}}, dec_imm[7:0]};
      else if (ni == 2) rec.immediate = dec_imm;
    end
  endtask

  // One random instruction, or now and then a stray or unknown byte
  task automatic push_random_instruction();
    logic [7:0]     op;
    logic [7:0]     m;
    mbd_pkg::form_t f;
    int             n;
    case ($urandom_range(0, 9))
      0, 1:    op = {mbd_pkg::OP_TOP_GRP, mbd_pkg::OP_MID_MOV_RM, 2'($urandom)};
      2, 3:    op = {mbd_pkg::OP_TOP_ADD, mbd_pkg::OP_MID_ZERO, 2'($urandom)};
      4, 5:    op = {mbd_pkg::OP_TOP_MOV_IMM, 1'b1, 4'($urandom)};
      6, 7:    op = {mbd_pkg::OP_TOP_GRP, mbd_pkg::OP_MID_ZERO, 2'($urandom)};
      8:       op = 8'($urandom);
      default: begin
        do op = 8'($urandom); while (form_of(op) != mbd_pkg::FORM_INVALID);
      end
    endcase
    rows.push_back({op, 1'b0});
    f = form_of(op);
    if (f == mbd_pkg::FORM_INVALID || $urandom_range(0, 9) == 8) return;
    m = 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      m[7:6] = mbd_pkg::MOD_MEM;
      m[2:0] = mbd_pkg::RM_DIRECT;
    end
    if (f != mbd_pkg::FORM_MOV_IMM) rows.push_back({m, 1'b0});
    n = disp_bytes(f, m) + imm_bytes(f, op);
    repeat (n) rows.push_back({data_byte(), 1'b0});
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ERROR decode: %s", $time, what);
  endtask

  // Receiver: ready held low a given share of cycles
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each accepted record with the oldest one predicted
  always @(posedge clk) begin
    mbd_pkg::mbd_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_records.size() == 0) begin
        report_mismatch("record with no instruction pending");
      end else begin
        want = pending_records.pop_front();
        if (out_ch.form !== want.form)
          report_mismatch($sformatf("form %0d, want %0d", out_ch.form, want.form));
        if (out_ch.wide !== want.wide)
          report_mismatch($sformatf("wide %0b, want %0b", out_ch.wide, want.wide));
        if (out_ch.reg_is_dest !== want.reg_is_dest)
          report_mismatch($sformatf("reg_is_dest %0b, want %0b",
                                    out_ch.reg_is_dest, want.reg_is_dest));
        if (out_ch.sign_extend !== want.sign_extend)
          report_mismatch($sformatf("sign_extend %0b, want %0b",
                                    out_ch.sign_extend, want.sign_extend));
        if (out_ch.mode !== want.mode)
          report_mismatch($sformatf("mode %0d, want %0d", out_ch.mode, want.mode));
        if (out_ch.reg_field !== want.reg_field)
          report_mismatch($sformatf("reg_field %0d, want %0d",
                                    out_ch.reg_field, want.reg_field));
        if (out_ch.rm_field !== want.rm_field)
          report_mismatch($sformatf("rm_field %0d, want %0d",
                                    out_ch.rm_field, want.rm_field));
        if (out_ch.displacement !== want.displacement)
          report_mismatch($sformatf("displacement %0d, want %0d",
                                    out_ch.displacement, want.displacement));
        if (out_ch.immediate !== want.immediate)
          report_mismatch($sformatf("immediate %0d, want %0d",
                                    out_ch.immediate, want.immediate));
        if (out_ch.length !== want.length)
          report_mismatch($sformatf("length %0d, want %0d", out_ch.length, want.length));
      end
    end
  end

  // Watchdog: too long without a request on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus: reset, directed table, random instructions, drain
  initial begin
    code_row_t         row;
    mbd_pkg::mbd_res_t rec;
    bit                done;
    int                n_rows;
    in_ch.valid     <= 1'b0;
    in_ch.code_byte <= '0;
    rst_n           <= 1'b0;

    bad_rec        = '0;
    bad_rec.form   = mbd_pkg::FORM_INVALID;
    bad_rec.length = 3'd1;

    foreach (DIRECTED[k]) rows.push_back({DIRECTED[k][7:0], DIRECTED[k][8]});
    while (rows.size() < $size(DIRECTED) + RANDOM_BYTES) push_random_instruction();
    n_rows = rows.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < n_rows; i++) begin
      row = rows[i];
      // idle phases: none, sender only, receiver only, both
      case ((i * 4) / n_rows)
        0:       begin send_gap_pct = 0;  recv_stall_pct <= 0;  end
        1:       begin send_gap_pct = 47; recv_stall_pct <= 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct <= 47; end
        default: begin send_gap_pct = 18; recv_stall_pct <= 18; end
      endcase
      while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.code_byte <= row.code;
      @(posedge clk);
      while (in_ch.ready !== 1'b1) @(posedge clk);
      decode_byte(row.code, done, rec);
      if (done) pending_records.push_back(row.typed_bad ? bad_rec : rec);
    end
    in_ch.valid <= 1'b0;

    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
